[rtl/pbw_pkg.sv]
`default_nettype none
package pbw_pkg;

   // Default width of the payload length counter
   localparam int LENGTH_WIDTH_DEFAULT = 32;

   // A varint gives up after this many bytes
   localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;

   // Wire types
   localparam logic [2:0] WIRE_VARINT  = 3'd0;
   localparam logic [2:0] WIRE_FIXED64 = 3'd1;
   localparam logic [2:0] WIRE_LENGTH  = 3'd2;
   localparam logic [2:0] WIRE_FIXED32 = 3'd5;

   // Last byte index of the fixed-width values
   localparam logic [2:0] FIX64_LAST = 3'd7;
   localparam logic [2:0] FIX32_LAST = 3'd3;

   // Record kinds
   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   typedef enum logic [5:0] {
      ST_KEY     = 6'b000001,
      ST_VARINT  = 6'b000010,
      ST_FIX64   = 6'b000100,
      ST_FIX32   = 6'b001000,
      ST_LEN     = 6'b010000,
      ST_PAYLOAD = 6'b100000
   } stage_type;

endpackage
`default_nettype wire

[rtl/protobuf_wire_stream_parser.sv]
`default_nettype none
// Protocol Buffers wire-format stream parser.
// Input channel (req_*): one message byte per beat, req_end_of_input high on
// the final byte of a message. Result channel (rsp_*): at most one record per
// input beat, either a field header (key, wire type, decoded value or payload
// length) or one payload byte of a length-delimited field, with flags for the
// last record of a field, a truncated field and the end of the message.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// Latency: a record caused by an input beat appears on rsp_* the cycle after
// that beat is accepted. Throughput: one byte per cycle; the parser state is
// updated in the same cycle the byte is taken, so there is no bubble.
// Stalls: a single output register holds the pending record. The input is
// stalled only while that register is full and the receiver stalls it, so the
// next byte is taken in the same cycle the held record is drained.
// Reset (synchronous, active high): parser expects a key, all state cleared,
// output register empty. After the final byte of a message the parser returns
// to that same state, so the next byte starts a new message.
module protobuf_wire_stream_parser #(
   parameter int LENGTH_WIDTH = pbw_pkg::LENGTH_WIDTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_input,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_record_kind,
   output logic [31:0]      rsp_field_number,
   output logic [2:0]       rsp_wire_type,
   output logic [63:0]      rsp_field_value,
   output logic [7:0]       rsp_payload_data,
   output logic             rsp_field_done,
   output logic             rsp_truncated,
   output logic             rsp_message_end
);

   localparam logic [63:0] LEN_MAX =
      {{(64 - LENGTH_WIDTH){1'b0}}, {LENGTH_WIDTH{1'b1}}};

   // parser state
   pbw_pkg::stage_type      stage_ff, stage_in;
   logic [63:0]             acc_ff, acc_in;
   logic [3:0]              vcnt_ff, vcnt_in;
   logic [31:0]             held_field_ff, held_field_in;
   logic [2:0]              held_wire_ff, held_wire_in;
   logic [2:0]              fcnt_ff, fcnt_in;
   logic [LENGTH_WIDTH-1:0] prem_ff, prem_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        kind_ff, kind_in;
   logic [31:0] field_ff, field_in;
   logic [2:0]  wire_ff, wire_in;
   logic [63:0] value_ff, value_in;
   logic [7:0]  data_ff, data_in;
   logic        done_ff, done_in;
   logic        trunc_ff, trunc_in;
   logic        mend_ff, mend_in;

   logic                    accept;
   logic                    emit;
   logic                    eoi;
   logic [7:0]              b;
   logic [6:0]              vshift;
   logic [63:0]             vacc;
   logic [3:0]              vcnt_inc;
   logic                    vdone;
   logic [63:0]             facc;
   logic [2:0]              flast;
   logic [63:0]             len_sat;
   logic [LENGTH_WIDTH-1:0] prem_dec;
   logic                    plast;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign b         = req_data_byte;
   assign eoi       = req_end_of_input;

   // varint byte: 7 bits at 7*count, dropped past the 64th bit
   assign vshift   = 7'({vcnt_ff, 3'b000}) - 7'(vcnt_ff);
   assign vacc     = (vcnt_ff < pbw_pkg::VARINT_MAX_BYTES)
                   ? (acc_ff | ({57'd0, b[6:0]} << vshift)) : acc_ff;
   assign vcnt_inc = vcnt_ff + 4'd1;
   assign vdone    = ~b[7] | (vcnt_inc >= pbw_pkg::VARINT_MAX_BYTES);

   // fixed value byte, little endian
   assign facc  = acc_ff | ({56'd0, b} << {fcnt_ff, 3'b000});
   assign flast = (stage_ff == pbw_pkg::ST_FIX64) ? pbw_pkg::FIX64_LAST
                                                  : pbw_pkg::FIX32_LAST;

   // length saturates to the counter width
   assign len_sat = (vacc > LEN_MAX) ? LEN_MAX : vacc;

   // payload countdown
   assign prem_dec = (prem_ff != '0) ? prem_ff - LENGTH_WIDTH'(1) : prem_ff;
   assign plast    = (prem_dec == '0);

   always_comb begin
      stage_in      = stage_ff;
      acc_in        = acc_ff;
      vcnt_in       = vcnt_ff;
      held_field_in = held_field_ff;
      held_wire_in  = held_wire_ff;
      fcnt_in       = fcnt_ff;
      prem_in       = prem_ff;

      emit     = 1'b0;
      kind_in  = pbw_pkg::KIND_HEADER;
      field_in = held_field_ff;
      wire_in  = held_wire_ff;
      value_in = 64'd0;
      data_in  = 8'd0;
      done_in  = 1'b1;
      trunc_in = 1'b0;
      mend_in  = eoi;

      case (stage_ff)
         pbw_pkg::ST_VARINT: begin
            acc_in  = vacc;
            vcnt_in = vcnt_inc;
            if (vdone | eoi) begin
               emit     = 1'b1;
               value_in = vacc;
               trunc_in = ~vdone;
            end
         end
         pbw_pkg::ST_FIX64, pbw_pkg::ST_FIX32: begin
            acc_in  = facc;
            fcnt_in = fcnt_ff + 3'd1;
            if (fcnt_ff >= flast) begin
               emit     = 1'b1;
               value_in = facc;
            end else if (eoi) begin
               emit     = 1'b1;
               trunc_in = 1'b1;
            end
         end
         pbw_pkg::ST_LEN: begin
            acc_in  = vacc;
            vcnt_in = vcnt_inc;
            if (vdone) begin
               emit = 1'b1;
               if (len_sat == 64'd0) begin
                  value_in = 64'd0;
               end else begin
                  value_in = len_sat;
                  done_in  = eoi;
                  trunc_in = eoi;
                  if (!eoi) begin
                     stage_in = pbw_pkg::ST_PAYLOAD;
                     prem_in  = len_sat[LENGTH_WIDTH-1:0];
                  end
               end
            end else if (eoi) begin
               emit     = 1'b1;
               value_in = len_sat;
               trunc_in = 1'b1;
            end
         end
         pbw_pkg::ST_PAYLOAD: begin
            emit     = 1'b1;
            kind_in  = pbw_pkg::KIND_PAYLOAD;
            data_in  = b;
            done_in  = plast | eoi;
            trunc_in = eoi & ~plast;
            prem_in  = prem_dec;
         end
         default: begin
            // key varint (unknown stage codes land here too)
            stage_in = pbw_pkg::ST_KEY;
            acc_in   = vacc;
            vcnt_in  = vcnt_inc;
            if (vdone) begin
               held_field_in = vacc[34:3];
               held_wire_in  = vacc[2:0];
               field_in      = vacc[34:3];
               wire_in       = vacc[2:0];
               acc_in        = 64'd0;
               vcnt_in       = 4'd0;
               case (vacc[2:0])
                  pbw_pkg::WIRE_VARINT:  stage_in = pbw_pkg::ST_VARINT;
                  pbw_pkg::WIRE_FIXED64: stage_in = pbw_pkg::ST_FIX64;
                  pbw_pkg::WIRE_FIXED32: stage_in = pbw_pkg::ST_FIX32;
                  pbw_pkg::WIRE_LENGTH:  stage_in = pbw_pkg::ST_LEN;
                  default: begin
                     // no body: header now
                     emit = 1'b1;
                  end
               endcase
               if (eoi) begin
                  emit     = 1'b1;
                  trunc_in = (vacc[2:0] == pbw_pkg::WIRE_VARINT)
                          || (vacc[2:0] == pbw_pkg::WIRE_FIXED64)
                          || (vacc[2:0] == pbw_pkg::WIRE_FIXED32)
                          || (vacc[2:0] == pbw_pkg::WIRE_LENGTH);
               end
            end else if (eoi) begin
               // message ends inside the key
               emit     = 1'b1;
               field_in = vacc[34:3];
               wire_in  = vacc[2:0];
               trunc_in = 1'b1;
            end
         end
      endcase

      // field complete or message over: back to key with cleared state
      if (eoi || (emit && done_in)) begin
         stage_in = pbw_pkg::ST_KEY;
         acc_in   = 64'd0;
         vcnt_in  = 4'd0;
         fcnt_in  = 3'd0;
         prem_in  = '0;
      end
   end

   always_comb begin
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff      <= pbw_pkg::ST_KEY;
         acc_ff        <= 64'd0;
         vcnt_ff       <= 4'd0;
         held_field_ff <= 32'd0;
         held_wire_ff  <= 3'd0;
         fcnt_ff       <= 3'd0;
         prem_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            stage_ff      <= stage_in;
            acc_ff        <= acc_in;
            vcnt_ff       <= vcnt_in;
            held_field_ff <= held_field_in;
            held_wire_ff  <= held_wire_in;
            fcnt_ff       <= fcnt_in;
            prem_ff       <= prem_in;
         end
      end
   end

   // record payload: loaded only with a new record
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         kind_ff  <= kind_in;
         field_ff <= field_in;
         wire_ff  <= wire_in;
         value_ff <= value_in;
         data_ff  <= data_in;
         done_ff  <= done_in;
         trunc_ff <= trunc_in;
         mend_ff  <= mend_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_record_kind  = kind_ff;
   assign rsp_field_number = field_ff;
   assign rsp_wire_type    = wire_ff;
   assign rsp_field_value  = value_ff;
   assign rsp_payload_data = data_ff;
   assign rsp_field_done   = done_ff;
   assign rsp_truncated    = trunc_ff;
   assign rsp_message_end  = mend_ff;

endmodule
`default_nettype wire

[tb/protobuf_wire_stream_parser_tb.sv]
`default_nettype none

// One decoded record as it leaves the parser.
typedef struct packed {
   logic        kind;
   logic [31:0] fnum;
   logic [2:0]  wtype;
   logic [63:0] value;
   logic [7:0]  data;
   logic        done;
   logic        trunc;
   logic        mend;
} wire_record_type;

// Tracks the wire-format parse of the byte stream and holds the records it implies.
class parse_scoreboard;
   wire_record_type     record_q[$];
   pbw_pkg::stage_type  stage;
   logic [63:0]         acc;
   logic [3:0]          vcount;
   logic [2:0]          fixed_cnt;
   logic [31:0]         remaining;
   logic [31:0]         held_fnum;
   logic [2:0]          held_wt;
   int unsigned         failures;
   int unsigned         headers;
   int unsigned         payloads;
   int unsigned         truncs;

   function new();
      held_fnum = '0;
      held_wt   = '0;
      failures  = 0;
      headers   = 0;
      payloads  = 0;
      truncs    = 0;
      clear();
   endfunction

   function void clear();
      stage     = pbw_pkg::ST_KEY;
      acc       = '0;
      vcount    = '0;
      fixed_cnt = '0;
      remaining = '0;
   endfunction

   function int pending();
      return record_q.size();
   endfunction

   // adds one varint byte, 1 when the varint is complete
   function bit add_varint_byte(logic [7:0] b);
      int unsigned sh;
      sh = 7 * vcount;
      if (sh < 64)
         acc |= {57'd0, b[6:0]} << sh;
      vcount = vcount + 4'd1;
      return !b[7] || vcount >= pbw_pkg::VARINT_MAX_BYTES;
   endfunction

   function logic [63:0] clamp_length(logic [63:0] v);
      logic [63:0] top;
      top = (64'd1 << pbw_pkg::LENGTH_WIDTH_DEFAULT) - 64'd1;
      return (v > top) ? top : v;
   endfunction

   function void push_expected(logic kind, logic [31:0] fnum, logic [2:0] wt,
                               logic [63:0] val, logic [7:0] data, logic done,
                               logic trunc, logic mend);
      record_q.push_back({kind, fnum, wt, val, data, done, trunc, mend});
   endfunction

   // one accepted message byte
   function void note_beat(logic [7:0] b, logic eoi);
      logic [63:0] len;
      logic [2:0]  last_idx;
      logic [2:0]  cnt;
      logic        known;
      case (stage)
         pbw_pkg::ST_VARINT: begin
            if (add_varint_byte(b)) begin
               push_expected(pbw_pkg::KIND_HEADER, held_fnum, held_wt, acc, 8'd0,
                             1'b1, 1'b0, eoi);
               clear();
            end else if (eoi) begin
               push_expected(pbw_pkg::KIND_HEADER, held_fnum, held_wt, acc, 8'd0,
                             1'b1, 1'b1, 1'b1);
               clear();
            end
         end
         pbw_pkg::ST_FIX64, pbw_pkg::ST_FIX32: begin
            last_idx = (stage == pbw_pkg::ST_FIX64) ? pbw_pkg::FIX64_LAST
                                                    : pbw_pkg::FIX32_LAST;
            cnt = fixed_cnt;
            acc |= {56'd0, b} << (8 * cnt);
            if (cnt >= last_idx) begin
               push_expected(pbw_pkg::KIND_HEADER, held_fnum, held_wt, acc, 8'd0,
                             1'b1, 1'b0, eoi);
               clear();
            end else begin
               fixed_cnt = cnt + 3'd1;
               // partial fixed value is dropped, never re-read as a key
               if (eoi) begin
                  push_expected(pbw_pkg::KIND_HEADER, held_fnum, held_wt, 64'd0, 8'd0,
                                1'b1, 1'b1, 1'b1);
                  clear();
               end
            end
         end
         pbw_pkg::ST_LEN: begin
            if (add_varint_byte(b)) begin
               len = clamp_length(acc);
               if (len == 64'd0) begin
                  push_expected(pbw_pkg::KIND_HEADER, held_fnum, held_wt, 64'd0, 8'd0,
                                1'b1, 1'b0, eoi);
                  clear();
               end else begin
                  push_expected(pbw_pkg::KIND_HEADER, held_fnum, held_wt, len, 8'd0,
                                eoi, eoi, eoi);
                  if (eoi) begin
                     clear();
                  end else begin
                     stage     = pbw_pkg::ST_PAYLOAD;
                     acc       = '0;
                     vcount    = '0;
                     remaining = len[31:0];
                  end
               end
            end else if (eoi) begin
               push_expected(pbw_pkg::KIND_HEADER, held_fnum, held_wt, clamp_length(acc),
                             8'd0, 1'b1, 1'b1, 1'b1);
               clear();
            end
         end
         pbw_pkg::ST_PAYLOAD: begin
            if (remaining != 32'd0)
               remaining = remaining - 32'd1;
            push_expected(pbw_pkg::KIND_PAYLOAD, held_fnum, held_wt, 64'd0, b,
                          (remaining == 32'd0) || eoi, eoi && (remaining != 32'd0), eoi);
            if (remaining == 32'd0 || eoi)
               clear();
         end
         default: begin
            stage = pbw_pkg::ST_KEY;
            if (!add_varint_byte(b)) begin
               if (eoi) begin
                  push_expected(pbw_pkg::KIND_HEADER, acc[34:3], acc[2:0], 64'd0, 8'd0,
                                1'b1, 1'b1, 1'b1);
                  clear();
               end
            end else begin
               held_fnum = acc[34:3];
               held_wt   = acc[2:0];
               clear();
               known = 1'b1;
               case (held_wt)
                  pbw_pkg::WIRE_VARINT:  stage = pbw_pkg::ST_VARINT;
                  pbw_pkg::WIRE_FIXED64: stage = pbw_pkg::ST_FIX64;
                  pbw_pkg::WIRE_FIXED32: stage = pbw_pkg::ST_FIX32;
                  pbw_pkg::WIRE_LENGTH:  stage = pbw_pkg::ST_LEN;
                  default: begin
                     known = 1'b0;
                     push_expected(pbw_pkg::KIND_HEADER, held_fnum, held_wt, 64'd0, 8'd0,
                                   1'b1, 1'b0, eoi);
                  end
               endcase
               if (known && eoi) begin
                  push_expected(pbw_pkg::KIND_HEADER, held_fnum, held_wt, 64'd0, 8'd0,
                                1'b1, 1'b1, 1'b1);
                  clear();
               end
            end
         end
      endcase
   endfunction

   function string show(wire_record_type r);
      return $sformatf({"kind=%0d field=%0d type=%0d value=%h data=%h ",
                        "done=%0d trunc=%0d end=%0d"},
                       r.kind, r.fnum, r.wtype, r.value, r.data, r.done, r.trunc, r.mend);
   endfunction

   function void log_mismatch(string what, string want_s, wire_record_type got);
      failures++;
      if (failures <= 10) begin
         $display("MISMATCH (%s)", what);
         $display("  expected %s", want_s);
         $display("  actual   %s", show(got));
      end
   endfunction

   // one accepted result record
   function void check_record(wire_record_type got);
      wire_record_type want;
      string           diff;
      if (got.kind == pbw_pkg::KIND_HEADER) headers++;
      else payloads++;
      if (got.trunc) truncs++;
      if (record_q.size() == 0) begin
         log_mismatch("record with nothing pending", "none", got);
         return;
      end
      want = record_q.pop_front();
      diff = "";
      if (got.kind  !== want.kind)  diff = {diff, " kind"};
      if (got.fnum  !== want.fnum)  diff = {diff, " field_number"};
      if (got.wtype !== want.wtype) diff = {diff, " wire_type"};
      if (got.value !== want.value) diff = {diff, " field_value"};
      if (got.data  !== want.data)  diff = {diff, " payload_data"};
      if (got.done  !== want.done)  diff = {diff, " field_done"};
      if (got.trunc !== want.trunc) diff = {diff, " truncated"};
      if (got.mend  !== want.mend)  diff = {diff, " message_end"};
      if (diff != "")
         log_mismatch({"wrong", diff}, show(want), got);
   endfunction

   // anything still queued at the end never came out
   function void close_out();
      while (record_q.size() != 0) begin
         failures++;
         if (failures <= 10)
            $display("MISSING record, expected %s", show(record_q.pop_front()));
         else
            void'(record_q.pop_front());
      end
   endfunction
endclass

module protobuf_wire_stream_parser_tb;

   // No beat in either direction for this many cycles means the parser hung.
   // Worst legal quiet stretch is one sender gap plus one receiver stall.
   localparam int unsigned WATCHDOG_LIMIT = 400;
   localparam int unsigned RANDOM_BEATS   = 1500;
   localparam int unsigned MSGS_PER_PHASE = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_end_of_input = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_record_kind;
   logic [31:0] rsp_field_number;
   logic [2:0]  rsp_wire_type;
   logic [63:0] rsp_field_value;
   logic [7:0]  rsp_payload_data;
   logic        rsp_field_done;
   logic        rsp_truncated;
   logic        rsp_message_end;

   parse_scoreboard sb;

   // Idle behavior per phase: 0 never waits, 1 may wait before every beat,
   // 2 waits only now and then.
   int unsigned tx_mode = 1;
   int unsigned rx_mode = 1;
   int unsigned beats_sent = 0;
   int unsigned messages_sent = 0;
   int unsigned idle_cycles = 0;
   bit          stim_done = 1'b0;

   logic [7:0] msg_q[$];         // bytes of the message being built
   logic [8:0] directed_q[$];    // bit 8 marks the final byte of a message

   always #10 clock = ~clock;

   protobuf_wire_stream_parser uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_record_kind  (rsp_record_kind),
      .rsp_field_number (rsp_field_number),
      .rsp_wire_type    (rsp_wire_type),
      .rsp_field_value  (rsp_field_value),
      .rsp_payload_data (rsp_payload_data),
      .rsp_field_done   (rsp_field_done),
      .rsp_truncated    (rsp_truncated),
      .rsp_message_end  (rsp_message_end)
   );

   function automatic int unsigned draw_wait(int unsigned mode);
      if (mode == 0)
         return 0;
      if (mode == 1)
         return $urandom_range(0, 13);
      return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
   endfunction

   // Append a varint. Occasionally padded with redundant continuation bytes,
   // which may push it past the 10-byte limit; the parser then gives up and
   // the leftover bytes fall into the next parse stage.
   function automatic void put_varint(logic [63:0] v);
      int unsigned pad;
      if ($urandom_range(0, 39) == 0) begin
         repeat (10 + $urandom_range(0, 2)) msg_q.push_back(8'hff);
         msg_q.push_back(8'h01);
         return;
      end
      pad = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
      while (v > 64'd127) begin
         msg_q.push_back({1'b1, v[6:0]});
         v = v >> 7;
      end
      if (pad > 0) begin
         msg_q.push_back({1'b1, v[6:0]});
         repeat (pad - 1) msg_q.push_back(8'h80);
         msg_q.push_back(8'h00);
      end else begin
         msg_q.push_back({1'b0, v[6:0]});
      end
   endfunction

   // Append one field with random content, not always well formed.
   function automatic void put_field();
      logic [63:0] fnum;
      logic [63:0] v;
      logic [2:0]  wt;
      int unsigned pick;
      int unsigned nbytes;
      pick = $urandom_range(0, 19);
      if (pick < 6)       wt = pbw_pkg::WIRE_VARINT;
      else if (pick < 12) wt = pbw_pkg::WIRE_LENGTH;
      else if (pick < 15) wt = pbw_pkg::WIRE_FIXED64;
      else if (pick < 18) wt = pbw_pkg::WIRE_FIXED32;
      else                wt = 3'($urandom_range(3, 7));
      if (wt == pbw_pkg::WIRE_FIXED32)
         wt = 3'd4 + 3'($urandom_range(0, 1)) * 3'd2;   // gives 4 or 6 sometimes
      if (pick == 16 || pick == 17)
         wt = pbw_pkg::WIRE_FIXED32;
      // small tags mostly; wide keys cover every field_number bit and keys
      // whose upper bits fall off the 32-bit field number
      case ($urandom_range(0, 3))
         0, 1: fnum = 64'($urandom_range(1, 31));
         2:    fnum = 64'($urandom);
         default: fnum = {$urandom, $urandom} >> 3;
      endcase
      put_varint({fnum[60:0], wt});
      case (wt)
         pbw_pkg::WIRE_VARINT:
            put_varint({$urandom, $urandom} >> $urandom_range(0, 63));
         pbw_pkg::WIRE_FIXED64:
            repeat (8) msg_q.push_back(8'($urandom_range(0, 255)));
         pbw_pkg::WIRE_FIXED32:
            repeat (4) msg_q.push_back(8'($urandom_range(0, 255)));
         pbw_pkg::WIRE_LENGTH: begin
            case ($urandom_range(0, 15))
               0: v = 64'd0;
               // huge lengths saturate; the message end cuts the payload short
               1: v = {$urandom, $urandom} >> $urandom_range(0, 40);
               default: v = 64'($urandom_range(1, 6));
            endcase
            put_varint(v);
            nbytes = (v > 64'd6) ? $urandom_range(0, 4) : int'(v);
            repeat (nbytes) msg_q.push_back(8'($urandom_range(0, 255)));
         end
         default: ;
      endcase
   endfunction

   // Move one byte across the input channel; returns once it is accepted.
   task automatic push_beat(input logic [7:0] b, input logic last);
      int unsigned n;
      n = draw_wait(tx_mode);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= b;
      req_end_of_input <= last;
      do @(posedge clock); while (req_stall);
      sb.note_beat(b, last);
      beats_sent++;
   endtask

   // Build and send one message. Most are well formed; some are cut short at
   // a random byte, some are plain noise, and a few carry no end flag so the
   // parse runs on into the next message.
   task automatic send_message();
      int unsigned ending;
      int unsigned cut;
      msg_q.delete();
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 8)) msg_q.push_back(8'($urandom_range(0, 255)));
      else
         repeat ($urandom_range(1, 4)) put_field();
      ending = $urandom_range(0, 9);
      if (ending < 2 && msg_q.size() > 1) begin
         cut = $urandom_range(0, msg_q.size() - 2);
         while (msg_q.size() > cut + 1) void'(msg_q.pop_back());
      end
      foreach (msg_q[i])
         push_beat(msg_q[i], (i == msg_q.size() - 1) && (ending != 9));
      messages_sent++;
   endtask

   // Hold the input idle until the parser has emitted everything it owes.
   // With nothing owed the caller drives the input in this same time step.
   task automatic drain_results();
      if (sb.pending() != 0) begin
         req_valid <= 1'b0;
         while (sb.pending() != 0) @(posedge clock);
      end
   endtask

   // Receiver: per record, optionally stall first, then take one.
   initial begin : receiver
      int unsigned n;
      forever begin
         n = draw_wait(rx_mode);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Result monitor: sample at the edge, before any of this edge's updates.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_record({rsp_record_kind, rsp_field_number, rsp_wire_type,
                          rsp_field_value, rsp_payload_data, rsp_field_done,
                          rsp_truncated, rsp_message_end});
   end

   // Watchdog: counts consecutive cycles in which nothing moves while work is owed.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (stim_done && sb.pending() == 0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TIMEOUT: nothing moved for %0d cycles, %0d records owed",
                  idle_cycles, sb.pending());
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned directed_count;
      sb = new();
      // Directed opening, bit 8 set on the final byte of a message:
      //   varint 127 on field 1; fixed32 all ones; two payload bytes;
      //   zero length; unknown wire type 3; end inside a fixed64 value;
      //   end inside a key; end right after a key; end on the byte that
      //   completes a nonzero length; end inside a payload; end inside a
      //   varint value.
      directed_q = '{9'h008, 9'h07f,
                     9'h00d, 9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff,
                     9'h012, 9'h002, 9'h000, 9'h0ff,
                     9'h01a, 9'h000,
                     9'h01b,
                     9'h009, 9'h011, 9'h122,
                     9'h180,
                     9'h110,
                     9'h012, 9'h103,
                     9'h012, 9'h005, 9'h0aa, 9'h1bb,
                     9'h008, 9'h1ff};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed bytes go back to back with a busy receiver
      tx_mode = 0;
      rx_mode = 1;
      foreach (directed_q[i])
         push_beat(directed_q[i][7:0], directed_q[i][8]);
      directed_count = beats_sent;
      drain_results();

      // random phases, each with its own idle mix, drained at every boundary
      while (beats_sent < directed_count + RANDOM_BEATS) begin
         tx_mode = $urandom_range(0, 2);
         rx_mode = $urandom_range(0, 2);
         repeat (MSGS_PER_PHASE) send_message();
         drain_results();
      end

      stim_done = 1'b1;
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      sb.close_out();

      $display("Sent %0d bytes in %0d messages (%0d directed) under mixed gaps and stalls.",
               beats_sent, messages_sent, directed_count);
      $display("Checked %0d header and %0d payload records, %0d truncated; %0d errors.",
               sb.headers, sb.payloads, sb.truncs, sb.failures);
      if (sb.failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
`default_nettype wire
